FILE: rtl/core/bounded_key_value_table_defines.svh
// Assertion macros used by the table's top-level RTL.
`ifndef BOUNDED_KEY_VALUE_TABLE_DEFINES_SVH
`define BOUNDED_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define BKVT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define BKVT_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BKVT_ASSERT_RST(lbl, prop, msg)
`define BKVT_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/bkvt_pkg.sv
// Types, codes and defaults for the bounded key-value table.
package bkvt_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 64;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam int DEF_ENTRIES     = 64;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 64;

    // actions
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    // update modes
    localparam logic [MODE_W-1:0] MODE_ANY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOEXIST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXIST   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD     = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADMODE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [MODE_W-1:0]   update_mode;
    } t_request;

    typedef struct packed {
        logic                hit;
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
    } t_result;

    // sequencer -> entry store controls
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic tag_valid;
        logic val_we;
    } t_mem_ctl;

endpackage

FILE: rtl/core/bounded_key_value_table.sv
// Bounded key-value table: top level with limit register, sequencer and entry store.
//
// Each request (lookup, update or delete) is taken when start is high and busy is
// low. The request then walks every entry through the single read port of the
// key memory, one entry per cycle, with one key comparator; that scan sets the
// latency. The result appears on o_result with o_done high for exactly one cycle,
// and busy falls in that same cycle, so the next request can be taken at the edge
// that ends the strobe. The receiver cannot stall the block; o_result holds its
// value until the next result, but o_done marks it only in its strobe cycle.
// After reset the block sweeps the tag memory to mark every entry free, with busy
// high, before the first request is taken. The entry limit register may be written
// at any time the block is idle and takes effect on the next insert; it resets
// to 64.
`include "bounded_key_value_table_defines.svh"

module bounded_key_value_table
    import bkvt_pkg::*;
#(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_request           i_req,
    output logic               o_done,
    output t_result            o_result,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    // stored key width: the request key port carries at most KEY_W bits
    localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int IW = $clog2(ENTRIES);

    logic [LIMIT_W-1:0] r_limit;
    t_mem_ctl           mem_ctl;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic [KW-1:0]      wr_key;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic               rd_valid;
    logic [KW-1:0]      rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;

    // entry limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    bkvt_seq #(
        .ENTRIES (ENTRIES),
        .KW      (KW),
        .VW      (VALUE_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .i_limit    (r_limit),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .o_mem_ctl  (mem_ctl),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_key   (wr_key),
        .o_wr_value (wr_value),
        .i_rd_valid (rd_valid),
        .i_rd_key   (rd_key),
        .i_rd_value (rd_value)
    );

    bkvt_store #(
        .ENTRIES (ENTRIES),
        .KW      (KW),
        .VW      (VALUE_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (mem_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_value (wr_value),
        .o_rd_valid (rd_valid),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

    // the clearing sweep follows every reset
    `BKVT_ASSERT_ANY(a_clear_after_reset, !i_rst_n |=> busy, "not busy after reset")
    // an accepted request keeps the block busy until its result
    `BKVT_ASSERT_RST(a_busy_after_start, (start && !busy) |=> (busy && !o_done), "accept not held")
    // a result strobe only comes as the block goes idle
    `BKVT_ASSERT_RST(a_done_idle, o_done |-> !busy, "result while busy")
    // full is reported only for a key that was absent
    `BKVT_ASSERT_RST(a_full_miss, (o_done && o_result.status == ST_FULL) |-> !o_result.hit,
                     "full on a present key")

endmodule

FILE: rtl/core/bkvt_store.sv
// Entry store: tag memory (valid + key) and value memory, registered reads.
module bkvt_store
    import bkvt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int KW      = DEF_KEY_WIDTH,
    parameter int VW      = DEF_VALUE_WIDTH,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [KW-1:0] i_wr_key,
    input  logic [VW-1:0] i_wr_value,
    output logic          o_rd_valid,
    output logic [KW-1:0] o_rd_key,
    output logic [VW-1:0] o_rd_value
);

    logic [KW:0]   r_tag_mem [ENTRIES];
    logic [VW-1:0] r_val_mem [ENTRIES];
    logic [KW:0]   r_rd_tag;
    logic [VW-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tag_we) begin
            r_tag_mem[i_wr_addr] <= {i_ctl.tag_valid, i_wr_key};
        end
        if (i_ctl.rd_en) begin
            r_rd_tag <= r_tag_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_value;
        end
        if (i_ctl.rd_en) begin
            r_rd_val <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_tag[KW];
    assign o_rd_key   = r_rd_tag[KW-1:0];
    assign o_rd_value = r_rd_val;

endmodule

FILE: rtl/core/bkvt_seq.sv
// Sequencer: clear sweep, per-entry scan with one key comparator, then commit.
module bkvt_seq
    import bkvt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int KW      = DEF_KEY_WIDTH,
    parameter int VW      = DEF_VALUE_WIDTH,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_request           i_req,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_busy,
    output logic               o_done,
    output t_result            o_result,
    output t_mem_ctl           o_mem_ctl,
    output logic [IW-1:0]      o_rd_addr,
    output logic [IW-1:0]      o_wr_addr,
    output logic [KW-1:0]      o_wr_key,
    output logic [VW-1:0]      o_wr_value,
    input  logic               i_rd_valid,
    input  logic [KW-1:0]      i_rd_key,
    input  logic [VW-1:0]      i_rd_value
);

    localparam int LCW   = $clog2(ENTRIES + 1);
    localparam int CMP_W = (LCW > LIMIT_W) ? LCW : LIMIT_W;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]     r_state, n_state;
    logic [IW-1:0]  r_idx, n_idx;
    logic           r_cmp_vld;
    logic [IW-1:0]  r_cmp_idx;
    t_request       r_req, n_req;
    logic           r_found, n_found;
    logic [IW-1:0]  r_match_idx, n_match_idx;
    logic [VW-1:0]  r_match_val, n_match_val;
    logic           r_free_found, n_free_found;
    logic [IW-1:0]  r_free_idx, n_free_idx;
    logic [LCW-1:0] r_live, n_live;
    logic           r_done, n_done;
    t_result        r_result, n_result;
    t_mem_ctl       mem_ctl;
    logic [IW-1:0]  wr_addr;
    logic           no_room;
    logic           mode_unmet;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_req        = r_req;
        n_found      = r_found;
        n_match_idx  = r_match_idx;
        n_match_val  = r_match_val;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_live       = r_live;
        n_done       = 1'b0;
        n_result     = r_result;
        mem_ctl      = '0;
        wr_addr      = r_idx;
        no_room      = !r_free_found || (CMP_W'(r_live) >= CMP_W'(i_limit));
        mode_unmet   = (r_req.update_mode == MODE_NOEXIST && r_found) ||
                       (r_req.update_mode == MODE_EXIST && !r_found);

        // compare stage, one entry per cycle
        if (r_cmp_vld) begin
            if (i_rd_valid && i_rd_key == r_req.key[KW-1:0] && !r_found) begin
                n_found     = 1'b1;
                n_match_idx = r_cmp_idx;
                n_match_val = i_rd_value;
            end
            if (!i_rd_valid && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_cmp_idx;
            end
        end

        case (r_state)
            S_CLEAR: begin
                mem_ctl.tag_we    = 1'b1;
                mem_ctl.tag_valid = 1'b0;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req        = i_req;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                mem_ctl.rd_en = 1'b1;
                if (r_idx == LAST) begin
                    n_state = S_TAIL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TAIL: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_result = '0;
                n_done   = 1'b1;
                n_state  = S_IDLE;
                case (r_req.action)
                    ACT_LOOKUP: begin
                        n_result.hit = r_found;
                        if (r_found) begin
                            n_result.read_value = VALUE_W'(r_match_val);
                        end
                    end
                    ACT_UPDATE: begin
                        n_result.hit = r_found;
                        if (r_req.update_mode == MODE_BAD) begin
                            n_result.status = ST_BADMODE;
                        end else if (mode_unmet) begin
                            n_result.status = ST_SKIPPED;
                        end else if (r_found) begin
                            mem_ctl.val_we = 1'b1;
                            wr_addr        = r_match_idx;
                        end else if (no_room) begin
                            n_result.status = ST_FULL;
                        end else begin
                            mem_ctl.tag_we    = 1'b1;
                            mem_ctl.tag_valid = 1'b1;
                            mem_ctl.val_we    = 1'b1;
                            wr_addr           = r_free_idx;
                            n_live            = r_live + LCW'(1);
                        end
                    end
                    ACT_DELETE: begin
                        n_result.hit = r_found;
                        if (r_found) begin
                            mem_ctl.tag_we = 1'b1;
                            wr_addr        = r_match_idx;
                            n_live         = r_live - LCW'(1);
                        end
                    end
                    default: begin
                        n_result.status = ST_BADMODE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_live       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_vld    <= mem_ctl.rd_en;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_live       <= n_live;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= r_idx;
        r_req       <= n_req;
        r_match_idx <= n_match_idx;
        r_match_val <= n_match_val;
        r_free_idx  <= n_free_idx;
        r_result    <= n_result;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_result   = r_result;
    assign o_mem_ctl  = mem_ctl;
    assign o_rd_addr  = r_idx;
    assign o_wr_addr  = wr_addr;
    assign o_wr_key   = r_req.key[KW-1:0];
    assign o_wr_value = r_req.value[VW-1:0];

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the bounded key-value table: stimulus, shadow table, checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bkvt_pkg::*;

    localparam int SLOTS = DEF_ENTRIES;

    // action 3 has no package code; the block must answer it with bad mode
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    t_request            op_bus    = '0;
    logic                done;
    t_result             reply_bus;
    logic                cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wdata = '0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bounded_key_value_table i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (op_bus),
        .o_done      (done),
        .o_result    (reply_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the table. Keys and values of free slots are never
    // read, since every search is gated by the valid bit.
    // ------------------------------------------------------------------
    logic                shadow_valid [SLOTS];
    logic [KEY_W-1:0]    shadow_key   [SLOTS];
    logic [VALUE_W-1:0]  shadow_value [SLOTS];
    int                  shadow_live  = 0;
    logic [LIMIT_W-1:0]  shadow_limit = LIMIT_RESET;

    t_request            queued_ops[$];        // requests not yet presented
    t_result             predicted_replies[$]; // replies owed by the block

    int                  n_issued    = 0;
    int                  n_checked   = 0;
    int                  n_errors    = 0;
    int                  n_hits      = 0;
    int                  status_seen [4];
    logic                steady_run  = 1'b0;   // back-to-back stretch, no idling
    int                  idle_left   = 0;

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            shadow_valid[s] = 1'b0;
        end
        for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
        end
    end

    // Applies one request to the shadow table and returns the reply it owes.
    function automatic t_result table_apply(input t_request op);
        t_result res;
        int      slot;
        int      free_slot;
        int      i;
        logic    present;
        res       = '0;
        res.status = ST_DONE;
        slot      = -1;
        free_slot = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && shadow_key[i] == op.key && slot < 0) begin
                slot = i;
            end
            if (!shadow_valid[i] && free_slot < 0) begin
                free_slot = i;
            end
        end
        present = (slot >= 0);
        case (op.action)
            ACT_LOOKUP: begin
                if (present) begin
                    res.hit        = 1'b1;
                    res.read_value = shadow_value[slot];
                end
            end
            ACT_UPDATE: begin
                res.hit = present;
                if (op.update_mode == MODE_BAD) begin
                    res.status = ST_BADMODE;
                end else if ((op.update_mode == MODE_NOEXIST && present) ||
                             (op.update_mode == MODE_EXIST && !present)) begin
                    res.status = ST_SKIPPED;
                end else if (present) begin
                    shadow_value[slot] = op.value;
                end else if (free_slot < 0 || shadow_live >= int'(shadow_limit)) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_key[free_slot]   = op.key;
                    shadow_value[free_slot] = op.value;
                    shadow_live++;
                end
            end
            ACT_DELETE: begin
                if (present) begin
                    res.hit            = 1'b1;
                    shadow_valid[slot] = 1'b0;
                    if (shadow_live > 0) begin
                        shadow_live--;
                    end
                end
            end
            default: begin
                res.status = ST_BADMODE;
            end
        endcase
        return res;
    endfunction

    function automatic t_request make_op(input logic [ACTION_W-1:0] act,
                                         input logic [KEY_W-1:0]    k,
                                         input logic [VALUE_W-1:0]  v,
                                         input logic [MODE_W-1:0]   m);
        t_request r;
        r.action      = act;
        r.key         = k;
        r.value       = v;
        r.update_mode = m;
        return r;
    endfunction

    // Mostly short gaps, some medium, a rare long one; none during a steady run.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run) begin
            return 0;
        end else if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued requests. A request is taken at an edge with
    // start high and busy low; start and the request bus get exactly one
    // update per edge, so a back-to-back request keeps start high.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : request_driver
        logic     nxt_start;
        t_request nxt_op;
        if (!rst_n) begin
            start     <= 1'b0;
            idle_left = 0;
        end else begin
            nxt_start = start;
            nxt_op    = op_bus;
            if (start && !busy) begin
                predicted_replies.push_back(table_apply(op_bus));
                n_issued++;
                nxt_start = 1'b0;
                if ($urandom_range(0, 19) == 0) begin
                    steady_run = !steady_run;
                end
                idle_left = pick_idle();
            end
            if (!nxt_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (queued_ops.size() > 0) begin
                    nxt_op    = queued_ops.pop_front();
                    nxt_start = 1'b1;
                end
            end
            start  <= nxt_start;
            op_bus <= nxt_op;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe and cannot be held off, so every
    // edge with done high carries a reply that is checked field by field.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : reply_checker
        t_result want;
        if (rst_n && done) begin
            if (predicted_replies.size() == 0) begin
                $display("%0t: reply with nothing outstanding, got hit %0b value %h status %0d",
                         $time, reply_bus.hit, reply_bus.read_value, reply_bus.status);
                n_errors++;
            end else begin
                want = predicted_replies.pop_front();
                n_checked++;
                if (reply_bus.hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b, got %0b",
                             $time, want.hit, reply_bus.hit);
                    n_errors++;
                end
                if (reply_bus.read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch, expected %h, got %h",
                             $time, want.read_value, reply_bus.read_value);
                    n_errors++;
                end
                if (reply_bus.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, reply_bus.status);
                    n_errors++;
                end
                if (want.hit) begin
                    n_hits++;
                end
                status_seen[want.status]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Block is idle once nothing is queued, presented or outstanding.
    // Checked on the falling edge, clear of the driver's updates.
    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (queued_ops.size() != 0 || start || predicted_replies.size() != 0);
    endtask

    // Limit write while idle; the shadow copy follows at the writing edge.
    task automatic set_limit(input logic [LIMIT_W-1:0] lim);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_limit = lim;
        @(negedge clk);
    endtask

    // Random requests over a small key pool so that hits, overwrites,
    // deletes and full tables all happen; a few keys come from outside it.
    task automatic queue_random(input int count, input int pool_size,
                                input int upd_pct, input int del_pct);
        logic [KEY_W-1:0]    pool[$];
        logic [ACTION_W-1:0] act;
        logic [KEY_W-1:0]    k;
        logic [VALUE_W-1:0]  v;
        logic [MODE_W-1:0]   m;
        int                  r;
        pool.push_back('0);
        pool.push_back({KEY_W{1'b1}});
        while (pool.size() < pool_size) begin
            pool.push_back(KEY_W'($urandom()));
        end
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                act = ACT_UNUSED;
            end else if (r < 4 + upd_pct) begin
                act = ACT_UPDATE;
            end else if (r < 4 + upd_pct + del_pct) begin
                act = ACT_DELETE;
            end else begin
                act = ACT_LOOKUP;
            end
            if ($urandom_range(0, 9) == 0) begin
                k = KEY_W'($urandom());
            end else begin
                k = pool[$urandom_range(0, pool.size() - 1)];
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                v = '0;
            end else if (r == 1) begin
                v = {VALUE_W{1'b1}};
            end else begin
                v = {$urandom(), $urandom()};
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                m = MODE_BAD;
            end else if (r < 50) begin
                m = MODE_ANY;
            end else if (r < 75) begin
                m = MODE_NOEXIST;
            end else begin
                m = MODE_EXIST;
            end
            queued_ops.push_back(make_op(act, k, v, m));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        // Directed part, reset limit of 64 in force.
        queued_ops.push_back(make_op(ACT_LOOKUP, 32'h0, 64'h0, MODE_ANY));      // empty miss
        queued_ops.push_back(make_op(ACT_DELETE, 32'h0, 64'h0, MODE_ANY));      // delete absent
        queued_ops.push_back(make_op(ACT_UPDATE, 32'hFFFF_FFFF,
                                     64'hFFFF_FFFF_FFFF_FFFF, MODE_ANY));       // first insert
        queued_ops.push_back(make_op(ACT_LOOKUP, 32'hFFFF_FFFF, 64'h0, MODE_ANY));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'hFFFF_FFFF, 64'h1, MODE_NOEXIST));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h0, 64'h2, MODE_EXIST));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'hFFFF_FFFF, 64'h0, MODE_EXIST));
        queued_ops.push_back(make_op(ACT_LOOKUP, 32'hFFFF_FFFF,
                                     64'hFFFF_FFFF_FFFF_FFFF, MODE_ANY));       // value ignored
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h0, 64'hA5A5_A5A5_A5A5_A5A5, MODE_NOEXIST));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h0, 64'h5A5A_5A5A_5A5A_5A5A, MODE_ANY));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h0, 64'h3, MODE_BAD));      // bad, present
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h1, 64'h4, MODE_BAD));      // bad, absent
        queued_ops.push_back(make_op(ACT_UNUSED, 32'h0, 64'h5, MODE_BAD));
        queued_ops.push_back(make_op(ACT_DELETE, 32'hFFFF_FFFF, 64'h0, MODE_ANY));
        queued_ops.push_back(make_op(ACT_LOOKUP, 32'hFFFF_FFFF, 64'h0, MODE_ANY));
        // freed slot 0 is reused before slot 2
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h1234_5678, 64'h6, MODE_ANY));
        queued_ops.push_back(make_op(ACT_LOOKUP, 32'h0, 64'h0, MODE_ANY));
        queued_ops.push_back(make_op(ACT_LOOKUP, 32'h1234_5678, 64'h0, MODE_ANY));
        queued_ops.push_back(make_op(ACT_DELETE, 32'h0, 64'h0, MODE_ANY));
        queued_ops.push_back(make_op(ACT_DELETE, 32'h1234_5678, 64'h0, MODE_ANY));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Limit of one: second new key is full, overwrites still go through.
        set_limit(7'd1);
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h7, 64'h7, MODE_ANY));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h8, 64'h8, MODE_ANY));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h7, 64'h9, MODE_ANY));
        queued_ops.push_back(make_op(ACT_DELETE, 32'h7, 64'h0, MODE_ANY));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h8, 64'h8, MODE_NOEXIST));

        // Zero limit: any new key is full.
        set_limit(7'd0);
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h8, 64'hA, MODE_EXIST));
        queued_ops.push_back(make_op(ACT_UPDATE, 32'h9, 64'hB, MODE_ANY));

        // Random phases; each set_limit call first waits for an idle, fully drained block.
        set_limit(7'd64);
        queue_random(120, 24, 40, 20);
        // Limit above capacity, insert heavy, so that the table can fill every slot.
        set_limit(7'd127);
        queue_random(150, 100, 75, 5);
        queue_random(60, 100, 30, 50);
        set_limit(7'd8);
        queue_random(100, 20, 45, 20);
        set_limit(7'd1);
        queue_random(60, 6, 45, 25);
        set_limit(7'd0);
        queue_random(30, 8, 50, 20);
        set_limit(7'd64);
        queue_random(100, 48, 50, 15);
        set_limit(LIMIT_W'($urandom_range(1, 127)));
        queue_random(80, 40, 45, 20);

        // Let the last reply land, then watch a full scan for strays.
        wait_drained();
        repeat (SLOTS + 8) @(posedge clk);

        $display("Issued %0d requests, checked %0d replies (%0d hits);",
                 n_issued, n_checked, n_hits);
        $display("limits 0, 1, 8, 64, 127 and one random; statuses: done %0d, skipped %0d, %s",
                 status_seen[0], status_seen[1], "");
        $display("full %0d, bad mode %0d.", status_seen[2], status_seen[3]);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial begin : watchdog
        #(5_000_000);
        $display("Timeout with %0d replies outstanding", predicted_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: bounded_key_value_table.f
+incdir+rtl/core
rtl/core/bkvt_pkg.sv
rtl/core/bkvt_store.sv
rtl/core/bkvt_seq.sv
rtl/core/bounded_key_value_table.sv
verif/tb_top.sv
